>>> rtl/smo_pkg.sv
// shared types and constants for the stack machine block
// no dependencies; imported by every rtl module of the block but smo_ram

package smo_pkg;

  // operation codes carried in the input tuser field
  localparam logic [2:0] FN_PUSH      = 3'd0;
  localparam logic [2:0] FN_PRINT_ALL = 3'd1;
  localparam logic [2:0] FN_PRINT_TOP = 3'd2;
  localparam logic [2:0] FN_POP       = 3'd3;
  localparam logic [2:0] FN_SWAP      = 3'd4;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_SHORT = 2'd2;
  localparam logic [1:0] STAT_FULL  = 2'd3;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned FUNC_W = 3;
  localparam int unsigned OUSER_W = 3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EMIT,
    S_SW_RD2,
    S_SW_WR1,
    S_SW_WR2,
    S_ERR
  } smo_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic       push;         // write push value at count, count + 1
    logic       pop;          // count - 1
    logic       rd_top;       // read entry count - 1
    logic       rd_second;    // read entry count - 2
    logic       hold_ld;      // capture read data into hold register
    logic       wr_top;       // write read data to entry count - 1
    logic       wr_second;    // write hold register to entry count - 2
    logic       ptr_set_top;  // walk pointer to count - 1
    logic       ptr_set_zero; // walk pointer to zero (single element)
    logic       ptr_step;     // read entry ptr - 1, ptr - 1
    logic       out_ld_data;  // load output with read data
    logic       out_ld_err;   // load output with error result
    logic [1:0] err_status;
  } smo_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic empty;
    logic full;
    logic short_swap;
    logic ptr_zero;
    logic out_free;
  } smo_sts_t;

endpackage

>>> rtl/smo_ram.sv
// generic single-port ram with registered read
// no dependencies

module smo_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> rtl/smo_ctrl.sv
// controller state machine for the stack machine block
// depends on smo_pkg; drives smo_dp through smo_cmd_t

module smo_ctrl
  import smo_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [FUNC_W-1:0] func,
  input  smo_sts_t          sts,
  output smo_cmd_t          cmd
);

  smo_state_t state_r, state_nxt;
  logic [1:0] err_r, err_nxt;
  logic       accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      err_r   <= STAT_OK;
    end else begin
      state_r <= state_nxt;
      err_r   <= err_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    err_nxt   = err_r;
    cmd       = '0;
    cmd.err_status = err_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (func)
            FN_PUSH: begin
              if (sts.full) begin
                err_nxt   = STAT_FULL;
                state_nxt = S_ERR;
              end else begin
                cmd.push = 1'b1;
              end
            end
            FN_PRINT_ALL: begin
              if (!sts.empty) begin
                cmd.rd_top      = 1'b1;
                cmd.ptr_set_top = 1'b1;
                state_nxt       = S_EMIT;
              end
            end
            FN_PRINT_TOP: begin
              if (sts.empty) begin
                err_nxt   = STAT_EMPTY;
                state_nxt = S_ERR;
              end else begin
                cmd.rd_top       = 1'b1;
                cmd.ptr_set_zero = 1'b1;
                state_nxt        = S_EMIT;
              end
            end
            FN_POP: begin
              if (sts.empty) begin
                err_nxt   = STAT_EMPTY;
                state_nxt = S_ERR;
              end else begin
                cmd.pop = 1'b1;
              end
            end
            FN_SWAP: begin
              if (sts.short_swap) begin
                err_nxt   = STAT_SHORT;
                state_nxt = S_ERR;
              end else begin
                cmd.rd_top = 1'b1;
                state_nxt  = S_SW_RD2;
              end
            end
            default: ;  // undefined opcodes are dropped
          endcase
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_ld_data = 1'b1;
          if (sts.ptr_zero) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.ptr_step = 1'b1;
          end
        end
      end
      S_SW_RD2: begin
        // top word is in read data now
        cmd.hold_ld   = 1'b1;
        cmd.rd_second = 1'b1;
        state_nxt     = S_SW_WR1;
      end
      S_SW_WR1: begin
        cmd.wr_top = 1'b1;
        state_nxt  = S_SW_WR2;
      end
      S_SW_WR2: begin
        cmd.wr_second = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_ERR: begin
        if (sts.out_free) begin
          cmd.out_ld_err = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

>>> rtl/smo_dp.sv
// datapath for the stack machine block: count, walk pointer, stack ram, output register
// depends on smo_pkg and smo_ram; commanded by smo_ctrl

module smo_dp
  import smo_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  smo_cmd_t           cmd,
  output smo_sts_t           sts,
  input  logic [DATA_W-1:0]  push_value,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [DATA_W-1:0]  out_tdata,
  output logic [OUSER_W-1:0] out_tuser,
  output logic               out_tlast
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] cnt_m1, cnt_m2;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [AW-1:0] ptr_m1;

  logic                    ram_we, ram_re;
  logic [AW-1:0]           ram_addr;
  logic [DATA_W-1:0]       ram_wdata, ram_rdata;
  logic signed [DATA_W-1:0] hold_r;

  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_data_r;
  logic                     out_has_r;
  logic [1:0]               out_status_r;
  logic                     out_last_r;

  assign cnt_m1 = count_r - CW'(1);
  assign cnt_m2 = count_r - CW'(2);
  assign ptr_m1 = ptr_r - AW'(1);

  assign sts.empty      = (count_r == '0);
  assign sts.full       = (count_r == CW'(STACK_DEPTH));
  assign sts.short_swap = (count_r < CW'(2));
  assign sts.ptr_zero   = (ptr_r == '0);
  assign sts.out_free   = !out_valid_r || out_tready;

  // single ram port, the controller never asks for two accesses at once
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = cnt_m1[AW-1:0];
    ram_wdata = ram_rdata;
    priority if (cmd.push) begin
      ram_we    = 1'b1;
      ram_addr  = count_r[AW-1:0];
      ram_wdata = push_value;
    end else if (cmd.rd_top) begin
      ram_re = 1'b1;
    end else if (cmd.rd_second) begin
      ram_re   = 1'b1;
      ram_addr = cnt_m2[AW-1:0];
    end else if (cmd.wr_top) begin
      ram_we = 1'b1;
    end else if (cmd.wr_second) begin
      ram_we    = 1'b1;
      ram_addr  = cnt_m2[AW-1:0];
      ram_wdata = hold_r;
    end else if (cmd.ptr_step) begin
      ram_re   = 1'b1;
      ram_addr = ptr_m1;
    end
  end

  smo_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    count_nxt = count_r;
    if (cmd.push) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.pop) begin
      count_nxt = cnt_m1;
    end
  end

  always_comb begin
    ptr_nxt = ptr_r;
    priority if (cmd.ptr_set_top) begin
      ptr_nxt = cnt_m1[AW-1:0];
    end else if (cmd.ptr_set_zero) begin
      ptr_nxt = '0;
    end else if (cmd.ptr_step) begin
      ptr_nxt = ptr_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.out_ld_data || cmd.out_ld_err) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (cmd.hold_ld) begin
      hold_r <= ram_rdata;
    end
    if (cmd.out_ld_data) begin
      out_data_r   <= ram_rdata;
      out_has_r    <= 1'b1;
      out_status_r <= STAT_OK;
      out_last_r   <= sts.ptr_zero;
    end else if (cmd.out_ld_err) begin
      out_data_r   <= '0;
      out_has_r    <= 1'b0;
      out_status_r <= cmd.err_status;
      out_last_r   <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = {out_status_r, out_has_r};
  assign out_tlast  = out_last_r;

endmodule

>>> rtl/stack_machine_ops_top.sv
// top level of the stack machine block: bounded lifo stack of signed 32-bit words
// depends on smo_pkg, smo_ctrl, smo_dp (which holds smo_ram)

// usage
//   input channel: one transaction per operation; in_tuser carries the opcode
//   (push, print all, print top, pop, swap), in_tdata the value for a push
//   result channel: data words and error reports; out_tuser holds has_data and
//   status, out_tlast marks the final result of one operation
//   successful push and pop keep in_tready high so they run back to back
//   print top: the top entry is read, then loaded into the output register once free
//   print all: the top entry is read first, then one element per cycle from top to
//   bottom while out_tready is high; the input waits until the bottom one is loaded
//   swap: two reads and two writes through the single ram port
//   errors (empty, short swap, full) give one result and leave the stack alone
//   opcodes five to seven are taken and dropped
//   reset clears the element count, output valid and controller state; the ram needs
//   no clearing pass since entries at or above the count are never read
//   a stalled receiver holds the output register; the next operation is still
//   taken, and only an operation that produces a result waits for the register
//   to free up

module stack_machine_ops_top
  import smo_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [DATA_W-1:0]  in_tdata,   // [31:0] push_value
  input  logic [FUNC_W-1:0]  in_tuser,   // [2:0] func
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [DATA_W-1:0]  out_tdata,  // [31:0] data
  output logic [OUSER_W-1:0] out_tuser,  // [0] has_data, [2:1] status
  output logic               out_tlast   // last
);

  smo_cmd_t cmd;
  smo_sts_t sts;

  // opcode decode and sequencing
  smo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .func      (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  // stack storage, count and result register
  smo_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .push_value (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

>>> rtl/smo_chk.sv
// port-level checker for the stack machine block, bound to the top level
// depends on smo_pkg and stack_machine_ops_top

module smo_chk
  import smo_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_tready,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [DATA_W-1:0]  out_tdata,
  input logic [OUSER_W-1:0] out_tuser,
  input logic               out_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // a data result always reports ok
  a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tuser[2:1] == STAT_OK)
    else $error("data result with error status");

  // an error result is alone, zero data, non-ok status
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |->
      out_tlast && out_tdata == '0 && out_tuser[2:1] != STAT_OK)
    else $error("malformed error result");

  // reset leaves the block idle with no pending result
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("not idle after reset");

endmodule

bind stack_machine_ops_top smo_chk u_chk (.*);

>>> test/tb_stack_machine_ops_top.sv
`timescale 1ns / 100ps
// testbench for stack_machine_ops_top: drives opcodes, predicts the lifo and checks every result
// depends on smo_pkg and the stack_machine_ops_top rtl only

module tb_stack_machine_ops_top;
  import smo_pkg::*;

  localparam int unsigned DEPTH        = 64;
  localparam int unsigned IDLE_PCT     = 18;    // chance of a gap or stall per cycle
  localparam int unsigned HOLD_CYCLES  = 250;   // long receiver hold-off
  localparam int unsigned WATCHDOG_MAX = 3000;  // cycles with no transaction at all
  localparam int unsigned DRAIN_CYCLES = 80;    // print all on a full stack plus margin
  localparam int unsigned RANDOM_OPS   = 360;

  // one result transaction, unpacked from the output ports
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              has_data;
    logic [1:0]        status;
    logic              last;
  } stack_result_t;

  // lifo predictor plus the queue of results it still owes
  class stack_scoreboard;
    logic [DATA_W-1:0] elems [DEPTH];
    int unsigned       depth_used;
    stack_result_t     owed_q[$];
    int unsigned       errors;
    int unsigned       n_ops;
    int unsigned       n_ignored;
    int unsigned       n_checked;
    int unsigned       n_full;
    int unsigned       peak_depth;

    function void owe_error(logic [1:0] st);
      owed_q.push_back('{data: '0, has_data: 1'b0, status: st, last: 1'b1});
    endfunction

    // called once per accepted input transaction
    function void note_op(logic [FUNC_W-1:0] fn, logic [DATA_W-1:0] value);
      logic [DATA_W-1:0] tmp;
      case (fn)
        FN_PUSH: begin
          if (depth_used == DEPTH) begin
            owe_error(STAT_FULL);
            n_full++;
          end else begin
            elems[depth_used] = value;
            depth_used++;
            if (depth_used > peak_depth) peak_depth = depth_used;
          end
        end
        FN_PRINT_ALL: begin
          // top first, last flag on the bottom element
          for (int i = depth_used; i > 0; i--)
            owed_q.push_back('{data: elems[i-1], has_data: 1'b1, status: STAT_OK,
                               last: (i == 1)});
        end
        FN_PRINT_TOP: begin
          if (depth_used == 0) owe_error(STAT_EMPTY);
          else owed_q.push_back('{data: elems[depth_used-1], has_data: 1'b1,
                                  status: STAT_OK, last: 1'b1});
        end
        FN_POP: begin
          if (depth_used == 0) owe_error(STAT_EMPTY);
          else depth_used--;
        end
        FN_SWAP: begin
          if (depth_used < 2) begin
            owe_error(STAT_SHORT);
          end else begin
            tmp = elems[depth_used-1];
            elems[depth_used-1] = elems[depth_used-2];
            elems[depth_used-2] = tmp;
          end
        end
        default: n_ignored++;
      endcase
      if (fn <= FN_SWAP) n_ops++;
    endfunction

    // called once per accepted output transaction
    function void check_result(stack_result_t got);
      stack_result_t want;
      n_checked++;
      if (owed_q.size() == 0) begin
        $error("result with nothing owed: data=%0d status=%0d", $signed(got.data), got.status);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (got.data !== want.data) begin
        $error("data: expected %0d, got %0d", $signed(want.data), $signed(got.data));
        errors++;
      end
      if (got.has_data !== want.has_data) begin
        $error("has_data: expected %0b, got %0b", want.has_data, got.has_data);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [DATA_W-1:0]  in_tdata = '0;   // [31:0] push_value
  logic [FUNC_W-1:0]  in_tuser = '0;   // [2:0] func
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [DATA_W-1:0]  out_tdata;       // [31:0] data
  logic [OUSER_W-1:0] out_tuser;       // [0] has_data, [2:1] status
  logic               out_tlast;

  stack_scoreboard sb = new();
  bit              no_idle = 1'b0;     // both sides run flat out while set
  int unsigned     quiet_cycles = 0;

  stack_machine_ops_top #(
    .STACK_DEPTH(DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // push values lean on the extremes of the signed range
  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // offer one transaction, with an occasional gap first; returns once accepted
  task automatic send_op(input logic [FUNC_W-1:0] fn, input logic [DATA_W-1:0] value);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_op(fn, value);
  endtask

  // weighted random opcode, pushes most common so the stack actually grows
  task automatic send_random_op();
    int unsigned w;
    w = $urandom_range(0, 99);
    if (w < 38)      send_op(FN_PUSH, pick_word());
    else if (w < 46) send_op(FN_PRINT_ALL, $urandom);
    else if (w < 60) send_op(FN_PRINT_TOP, $urandom);
    else if (w < 80) send_op(FN_POP, $urandom);
    else if (w < 94) send_op(FN_SWAP, $urandom);
    else             send_op(FUNC_W'($urandom_range(FN_SWAP + 1, 7)), $urandom);
  endtask

  // push up to full, run into overflow, swap, then read everything back
  task automatic fill_stack();
    while (sb.depth_used < DEPTH) send_op(FN_PUSH, pick_word());
    repeat ($urandom_range(1, 2)) send_op(FN_PUSH, pick_word());
    send_op(FN_SWAP, $urandom);
    send_op(FN_PRINT_ALL, $urandom);
    send_op(FN_PRINT_TOP, $urandom);
  endtask

  // pop down to empty and hit every empty-stack error
  task automatic drain_stack();
    while (sb.depth_used > 0) send_op(FN_POP, $urandom);
    send_op(FN_POP, $urandom);
    send_op(FN_PRINT_TOP, $urandom);
    send_op(FN_SWAP, $urandom);
    send_op(FN_PRINT_ALL, $urandom);
  endtask

  // result side: random stalls, one long hold-off once results are flowing
  initial begin
    bit held = 1'b0;
    wait (rst_n);
    forever begin
      if (!held && sb.n_checked >= 30) begin
        // long hold-off so the output register fills and in_tready drops
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        @(posedge clk);
        if (out_tvalid && out_tready)
          sb.check_result('{data: out_tdata, has_data: out_tuser[0],
                            status: out_tuser[2:1], last: out_tlast});
      end
    end
  end

  // watchdog: any accepted transaction on either side resets the count
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_MAX) begin
        $display("watchdog: no transaction for %0d cycles, %0d results still owed",
                 quiet_cycles, sb.pending());
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // stimulus: reset, directed corner cases, then random scenarios
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // errors on an empty stack, print all with nothing to print
    send_op(FN_PRINT_TOP, 32'hFFFF_FFFF);
    send_op(FN_POP, 32'h0);
    send_op(FN_SWAP, 32'h0);
    send_op(FN_PRINT_ALL, 32'h0);
    // single element: swap too short, print all marks it last
    send_op(FN_PUSH, 32'h8000_0000);
    send_op(FN_SWAP, 32'hFFFF_FFFF);
    send_op(FN_PRINT_ALL, 32'h0);
    // extremes of the value range, then a successful swap
    send_op(FN_PUSH, 32'h7FFF_FFFF);
    send_op(FN_PUSH, 32'h0000_0000);
    send_op(FN_PUSH, 32'hFFFF_FFFF);
    send_op(FN_SWAP, 32'h0);
    send_op(FN_PRINT_ALL, 32'h0);
    send_op(FN_PRINT_TOP, 32'h0);
    // undefined opcodes must leave the stack alone
    send_op(3'd5, 32'hFFFF_FFFF);
    send_op(3'd6, 32'h5555_5555);
    send_op(3'd7, 32'hAAAA_AAAA);
    send_op(FN_PRINT_TOP, 32'h0);
    // pop back to empty and one more
    send_op(FN_POP, 32'h0);
    send_op(FN_PRINT_TOP, 32'h0);
    repeat (3) send_op(FN_POP, 32'h0);
    send_op(FN_POP, 32'h0);
    send_op(FN_PRINT_ALL, 32'h0);

    // one guaranteed overflow pass and drain, then a random mix of scenarios
    fill_stack();
    drain_stack();
    while (sb.n_ops < RANDOM_OPS) begin
      int unsigned pick;
      no_idle = (sb.n_ops >= 160 && sb.n_ops < 230);
      pick = $urandom_range(0, 99);
      if (pick < 8)       fill_stack();
      else if (pick < 18) drain_stack();
      else repeat ($urandom_range(8, 20)) send_random_op();
    end
    no_idle = 1'b0;
    in_tvalid <= 1'b0;

    // everything owed must arrive, then allow for work still in flight
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d operations and %0d ignored opcodes, %0d results checked",
             sb.n_ops, sb.n_ignored, sb.n_checked);
    $display("peak depth %0d of %0d, %0d pushes onto a full stack",
             sb.peak_depth, DEPTH, sb.n_full);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
